>>> rtl/core/nce_pkg.sv
// Shared types, opcodes and helpers for the nibble processor execute block.
package nce_pkg;

    localparam int unsigned MEM_DEPTH = 16;
    localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

    // Standalone opcodes (whole byte 0x00..0x0F)
    localparam logic [7:0] OP_HALT = 8'h00;
    localparam logic [7:0] OP_RET  = 8'h01;
    localparam logic [7:0] OP_MOVS = 8'h02;
    localparam logic [7:0] OP_NOT  = 8'h03;
    localparam logic [7:0] OP_RSH  = 8'h04;
    localparam logic [7:0] OP_LSH  = 8'h05;
    localparam logic [7:0] OP_ROR  = 8'h06;
    localparam logic [7:0] OP_ROL  = 8'h07;
    localparam logic [7:0] OP_IN   = 8'h08;
    localparam logic [7:0] OP_OUT  = 8'h09;
    localparam logic [7:0] OP_BELL = 8'h0A;
    // Opcodes carried in the high nibble
    localparam logic [7:0] OP_ADD  = 8'h10;
    localparam logic [7:0] OP_SUB  = 8'h20;
    localparam logic [7:0] OP_XOR  = 8'h30;
    localparam logic [7:0] OP_OR   = 8'h40;
    localparam logic [7:0] OP_LDI  = 8'h50;
    localparam logic [7:0] OP_ST   = 8'h60;
    localparam logic [7:0] OP_LD   = 8'h70;
    // Opcodes carried in the top two bits
    localparam logic [7:0] OP_JNC  = 8'h80;
    localparam logic [7:0] OP_CALL = 8'hC0;

    typedef struct packed {
        logic [7:0] instruction;
        logic [7:0] input_value;
    } t_in_item;

    typedef struct packed {
        logic [5:0] next_pc;
        logic       out_valid;
        logic [3:0] out_value;
        logic       bell;
        logic       halted;
        logic       bad_opcode;
        logic       carry_out;
        logic [3:0] dest_value;
    } t_out_item;

    typedef struct packed {
        logic [5:0] pc;
        logic [5:0] link;
        logic [3:0] src;
        logic [3:0] dest;
        logic       carry;
        logic       halt;
    } t_arch_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        data;
    } t_mem_wr;

    // Data memory address used by an instruction byte; standalone ops use entry zero.
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [7:0] byte_in);
        logic [ADDR_W-1:0] a;
        a = (byte_in[7:4] == 4'h0) ? '0 : byte_in[ADDR_W-1:0];
        return a;
    endfunction

endpackage

>>> rtl/core/nibble_cpu_execute.sv
// Top level of the nibble processor execute block.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one request per
//   instruction byte plus the value used by the in instruction. Output channel
//   (o_out_valid / i_out_stall / o_out_data) returns one status request per
//   instruction: next pc, out strobe and value, bell, halt, error, carry, dest.
// Pipeline:
//   The accepting edge registers the operand nibble read from the data memory.
//   The execute stage then executes, updates the registers, writes back on store
//   and loads the output register. One instruction is taken every cycle while the
//   output is not stalled; a store followed at once by a read of the same nibble
//   is served through the memory write bypass.
// Reset:
//   Synchronous, active low. Clears pc, link, source, dest, carry and halt and
//   marks all sixteen data nibbles as reading zero; no clearing pass is needed.
// Stall:
//   While the output request is stalled it holds; an instruction in the execute
//   stage then holds too and o_in_stall rises until the output register drains.
module nibble_cpu_execute (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nce_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nce_pkg::t_out_item o_out_data
);

    // execute stage request and architectural registers
    logic                 r_ex_vld;
    nce_pkg::t_in_item    r_ex_item;
    nce_pkg::t_arch_state r_state;
    nce_pkg::t_arch_state n_state;

    // output register
    logic                 r_out_vld;
    nce_pkg::t_out_item   r_out_item;
    nce_pkg::t_out_item   n_out_item;

    logic                 out_rdy;
    logic                 ex_go;
    logic                 in_acc;
    logic [3:0]           mem_data;
    nce_pkg::t_mem_wr     ex_wr;
    nce_pkg::t_mem_wr     mem_wr;

    // output register frees when empty or being taken this cycle
    assign out_rdy    = !r_out_vld || !i_out_stall;
    assign ex_go      = r_ex_vld && out_rdy;
    // hold new requests while the execute stage is blocked
    assign o_in_stall = r_ex_vld && !out_rdy;
    assign in_acc     = i_in_valid && !o_in_stall;

    // commit a store only when its instruction retires
    always_comb begin
        mem_wr    = ex_wr;
        mem_wr.en = ex_wr.en && ex_go;
    end

    nce_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (nce_pkg::mem_addr(i_in_data.instruction)),
        .i_wr      (mem_wr),
        .o_rd_data (mem_data)
    );

    nce_alu u_alu (
        .i_instruction (r_ex_item.instruction),
        .i_input_value (r_ex_item.input_value),
        .i_mem_data    (mem_data),
        .i_state       (r_state),
        .o_state       (n_state),
        .o_wr          (ex_wr),
        .o_result      (n_out_item)
    );

    // payload registers: load on accept / retire, otherwise hold
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ex_item <= i_in_data;
        end
        if (ex_go) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            // advance execute stage: refill on accept, drop when it retires alone
            if (in_acc) begin
                r_ex_vld <= 1'b1;
            end else if (ex_go) begin
                r_ex_vld <= 1'b0;
            end
            if (ex_go) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

endmodule

>>> rtl/core/nce_mem.sv
// Sixteen-nibble data memory with registered read, per-entry valid bits and write bypass.
module nce_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [nce_pkg::ADDR_W-1:0] i_rd_addr,
    input  nce_pkg::t_mem_wr           i_wr,
    output logic [3:0]                 o_rd_data
);

    logic [3:0]                      r_mem [nce_pkg::MEM_DEPTH];
    logic [nce_pkg::MEM_DEPTH-1:0]   r_valid;
    logic [3:0]                      r_q;
    logic                            r_q_vld;
    logic                            r_fwd;
    logic [3:0]                      r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_q_vld <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_valid[i_rd_addr];
                // take the write data when the same entry is written this cycle
                r_fwd   <= i_wr.en && (i_wr.addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_q_vld ? r_q : 4'h0);

endmodule

>>> rtl/core/nce_alu.sv
// Decode and execute of one instruction byte against the register state.
module nce_alu (
    input  logic [7:0]           i_instruction,
    input  logic [7:0]           i_input_value,
    input  logic [3:0]           i_mem_data,
    input  nce_pkg::t_arch_state i_state,
    output nce_pkg::t_arch_state o_state,
    output nce_pkg::t_mem_wr     o_wr,
    output nce_pkg::t_out_item   o_result
);

    logic [7:0] op;
    logic [5:0] arg;
    logic [5:0] pc_inc;
    logic [3:0] src;
    logic [4:0] sum;
    logic [4:0] diff;
    logic       ov;
    logic       bel;
    logic       bad;
    nce_pkg::t_arch_state st;

    always_comb begin
        if (i_instruction[7:4] == 4'h0) begin
            op  = i_instruction;
            arg = 6'h00;
        end else if (i_instruction > 8'h80) begin
            op  = {i_instruction[7:6], 6'h00};
            arg = i_instruction[5:0];
        end else begin
            op  = {i_instruction[7:4], 4'h0};
            arg = {2'b00, i_instruction[3:0]};
        end
    end

    assign pc_inc = i_state.pc + 6'd1;
    assign src    = i_state.src;
    assign sum    = {1'b0, src} + {1'b0, i_mem_data};
    assign diff   = {1'b0, src} - {1'b0, i_mem_data};

    always_comb begin
        st      = i_state;
        st.pc   = pc_inc;
        ov      = 1'b0;
        bel     = 1'b0;
        bad     = 1'b0;
        o_wr.en   = 1'b0;
        o_wr.addr = arg[nce_pkg::ADDR_W-1:0];
        o_wr.data = i_state.dest;
        case (op)
            nce_pkg::OP_ADD: begin
                st.carry = sum[4];
                st.dest  = sum[3:0];
            end
            nce_pkg::OP_SUB: begin
                st.carry = diff[4];
                st.dest  = diff[3:0];
            end
            nce_pkg::OP_XOR:  st.dest = src ^ i_mem_data;
            nce_pkg::OP_OR:   st.dest = src | i_mem_data;
            nce_pkg::OP_LDI:  st.dest = arg[3:0];
            nce_pkg::OP_ST:   o_wr.en = 1'b1;
            nce_pkg::OP_LD:   st.src  = i_mem_data;
            nce_pkg::OP_JNC: begin
                if (!i_state.carry) begin
                    st.pc = arg;
                end
            end
            nce_pkg::OP_CALL: begin
                st.link = pc_inc;
                st.pc   = arg;
            end
            nce_pkg::OP_HALT: st.halt = 1'b1;
            nce_pkg::OP_RET:  st.pc   = i_state.link;
            nce_pkg::OP_MOVS: st.src  = i_state.dest;
            nce_pkg::OP_NOT:  st.dest = ~src;
            nce_pkg::OP_RSH: begin
                st.dest  = {1'b0, src[3:1]};
                st.carry = src[0];
            end
            nce_pkg::OP_LSH: begin
                st.carry = src[3];
                st.dest  = {src[2:0], 1'b0};
            end
            nce_pkg::OP_ROR:  st.dest = {src[0], src[3:1]};
            nce_pkg::OP_ROL:  st.dest = {src[2:0], src[3]};
            nce_pkg::OP_IN:   st.dest = i_input_value[3:0];
            nce_pkg::OP_OUT:  ov      = 1'b1;
            nce_pkg::OP_BELL: bel     = 1'b1;
            default:          bad     = 1'b1;
        endcase
    end

    assign o_state = st;

    always_comb begin
        o_result.next_pc    = st.pc;
        o_result.out_valid  = ov;
        o_result.out_value  = ov ? i_state.dest : 4'h0;
        o_result.bell       = bel;
        o_result.halted     = st.halt;
        o_result.bad_opcode = bad;
        o_result.carry_out  = st.carry;
        o_result.dest_value = st.dest;
    end

endmodule

>>> rtl/core/nce_checker.sv
// Port-level checks for the nibble processor execute block, bound to its top level.
module nce_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input nce_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input nce_pkg::t_out_item o_out_data
);

    logic r_seen_halt;

    // remember that a halted result was delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_out_data.halted) begin
            r_seen_halt <= 1'b1;
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input request changed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output request changed");

    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_out_data.out_valid, o_out_data.bell,
                                    o_out_data.bad_opcode}) <= 1)
        else $error("more than one event flag in a result");

    a_out_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.out_valid |-> o_out_data.out_value == 4'h0)
        else $error("out value shown without out strobe");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_halt |-> o_out_data.halted)
        else $error("halt flag cleared after being set");

endmodule

bind nibble_cpu_execute nce_checker u_nce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> test/nce_status_checker.sv
// Status checker for the nibble processor execute block: predicts and compares each result.
module nce_status_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  nce_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  nce_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Machine state as the predictor sees it
    logic [5:0] pc_q;
    logic [5:0] link_q;
    logic [3:0] src_q;
    logic [3:0] dest_q;
    logic       carry_q;
    logic       halt_q;
    logic [3:0] nibbles_q [nce_pkg::MEM_DEPTH];

    nce_pkg::t_out_item status_queue [$];

    // Execute one instruction byte on the predicted state and return its status.
    function automatic nce_pkg::t_out_item execute_instruction(input nce_pkg::t_in_item req);
        nce_pkg::t_out_item st;
        logic [7:0] op;
        logic [5:0] arg;
        logic [3:0] operand;
        logic [4:0] sum;
        st = '0;
        if (req.instruction < nce_pkg::OP_ADD) begin
            op  = req.instruction;
            arg = '0;
        end else if (req.instruction > nce_pkg::OP_JNC) begin
            op  = {req.instruction[7:6], 6'b0};
            arg = req.instruction[5:0];
        end else begin
            op  = {req.instruction[7:4], 4'b0};
            arg = {2'b0, req.instruction[3:0]};
        end
        pc_q    = pc_q + 6'd1;
        operand = nibbles_q[arg[3:0]];
        case (op)
            nce_pkg::OP_ADD: begin
                sum     = {1'b0, src_q} + {1'b0, operand};
                carry_q = sum[4];
                dest_q  = sum[3:0];
            end
            nce_pkg::OP_SUB: begin
                carry_q = (src_q < operand);
                dest_q  = src_q - operand;
            end
            nce_pkg::OP_XOR:  dest_q = src_q ^ operand;
            nce_pkg::OP_OR:   dest_q = src_q | operand;
            nce_pkg::OP_LDI:  dest_q = arg[3:0];
            nce_pkg::OP_ST:   nibbles_q[arg[3:0]] = dest_q;
            nce_pkg::OP_LD:   src_q = operand;
            nce_pkg::OP_JNC: begin
                if (!carry_q) pc_q = arg;
            end
            nce_pkg::OP_CALL: begin
                link_q = pc_q;
                pc_q   = arg;
            end
            nce_pkg::OP_HALT: halt_q = 1'b1;
            nce_pkg::OP_RET:  pc_q = link_q;
            nce_pkg::OP_MOVS: src_q = dest_q;
            nce_pkg::OP_NOT:  dest_q = ~src_q;
            nce_pkg::OP_RSH: begin
                carry_q = src_q[0];
                dest_q  = {1'b0, src_q[3:1]};
            end
            nce_pkg::OP_LSH: begin
                carry_q = src_q[3];
                dest_q  = {src_q[2:0], 1'b0};
            end
            nce_pkg::OP_ROR:  dest_q = {src_q[0], src_q[3:1]};
            nce_pkg::OP_ROL:  dest_q = {src_q[2:0], src_q[3]};
            nce_pkg::OP_IN:   dest_q = req.input_value[3:0];
            nce_pkg::OP_OUT: begin
                st.out_valid = 1'b1;
                st.out_value = dest_q;
            end
            nce_pkg::OP_BELL: st.bell = 1'b1;
            default: st.bad_opcode = 1'b1;
        endcase
        st.next_pc    = pc_q;
        st.halted     = halt_q;
        st.carry_out  = carry_q;
        st.dest_value = dest_q;
        return st;
    endfunction

    function automatic void report_field(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
        $display("%0t ns: mismatch on %s, expected %0h, actual %0h", $time, field, want, got);
        o_fail_count++;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        nce_pkg::t_out_item want;
        if (!i_rst_n) begin
            pc_q    = '0;
            link_q  = '0;
            src_q   = '0;
            dest_q  = '0;
            carry_q = 1'b0;
            halt_q  = 1'b0;
            foreach (nibbles_q[k]) nibbles_q[k] = '0;
            status_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (status_queue.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    want = status_queue.pop_front();
                    o_checked++;
                    if (i_out_data.next_pc !== want.next_pc)
                        report_field("next_pc", 8'(want.next_pc),
                                     8'(i_out_data.next_pc));
                    if (i_out_data.out_valid !== want.out_valid)
                        report_field("out_valid", 8'(want.out_valid),
                                     8'(i_out_data.out_valid));
                    if (i_out_data.out_value !== want.out_value)
                        report_field("out_value", 8'(want.out_value),
                                     8'(i_out_data.out_value));
                    if (i_out_data.bell !== want.bell)
                        report_field("bell", 8'(want.bell), 8'(i_out_data.bell));
                    if (i_out_data.halted !== want.halted)
                        report_field("halted", 8'(want.halted), 8'(i_out_data.halted));
                    if (i_out_data.bad_opcode !== want.bad_opcode)
                        report_field("bad_opcode", 8'(want.bad_opcode),
                                     8'(i_out_data.bad_opcode));
                    if (i_out_data.carry_out !== want.carry_out)
                        report_field("carry_out", 8'(want.carry_out),
                                     8'(i_out_data.carry_out));
                    if (i_out_data.dest_value !== want.dest_value)
                        report_field("dest_value", 8'(want.dest_value),
                                     8'(i_out_data.dest_value));
                end
            end
            if (i_in_valid && !i_in_stall)
                status_queue.push_back(execute_instruction(i_in_data));
        end
        o_pending = status_queue.size();
    end

endmodule

>>> test/tb_nibble_cpu_execute.sv
// Testbench top for the nibble processor execute block: stimulus, idling and verdict.
module tb_nibble_cpu_execute;
    timeunit 1ns;
    timeprecision 1ps;

    // Bytes 0x0B..0x0F decode to no instruction
    localparam logic [7:0] OP_UNKNOWN_FIRST = nce_pkg::OP_BELL + 8'd1;
    localparam logic [7:0] OP_UNKNOWN_LAST  = nce_pkg::OP_ADD - 8'd1;
    localparam int         RANDOM_ITEMS     = 1000;
    localparam int         QUIET_ITEMS      = 100;
    localparam int         PAUSE_AT         = 300;
    localparam int         DRAIN_CYCLES     = 10;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    nce_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    nce_pkg::t_out_item o_out_data;

    int        fail_count;
    int        pending;
    int        checked;
    int        sent_count;
    logic      quiet_phase;

    nibble_cpu_execute DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    nce_status_checker u_status_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit: far beyond the slowest correct run, with every request hit by the
    // longest sender gap and the longest receiver stall
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: stall in random bursts; drop all stalls in the quiet phase at the
    // end so that stretch runs at full rate.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (quiet_phase) begin
                stall_left = 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    // Present one request, optionally after an idle burst, and hold it until
    // accepted. Enter and leave at a falling edge.
    task automatic send_request(input logic [7:0] instr, input logic [7:0] value);
        nce_pkg::t_in_item req;
        int                gap;
        req.instruction = instr;
        req.input_value = value;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
        @(negedge i_clk);
    endtask

    // Random instruction byte, weighted toward the memory-operand ops so the
    // data nibbles fill with real content; jumps and calls keep the pc moving.
    function automatic logic [7:0] random_instruction();
        logic [7:0] instr;
        case ($urandom_range(0, 9))
            0, 1, 2:       instr = 8'($urandom_range(nce_pkg::OP_HALT, OP_UNKNOWN_LAST));
            3, 4, 5, 6, 7: instr = 8'($urandom_range(nce_pkg::OP_ADD,
                                                     nce_pkg::OP_JNC - 8'd1));
            8:             instr = 8'($urandom_range(nce_pkg::OP_JNC,
                                                     nce_pkg::OP_CALL - 8'd1));
            default:       instr = 8'($urandom_range(nce_pkg::OP_CALL, 8'hFF));
        endcase
        return instr;
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        quiet_phase = 1'b0;
        sent_count  = 0;

        // Hold reset low, then release it at a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: extremes of the operands, every instruction, carry and
        // borrow, both outcomes of jump-if-no-carry, rotate-left taking bit 3,
        // a call to 63 and the return to its link, unknown opcodes, and execution after halt.
        send_request(nce_pkg::OP_LDI | 8'h0F, 8'h00);   // dest = 15
        send_request(nce_pkg::OP_ST  | 8'h0F, 8'h00);   // top nibble = 15
        send_request(nce_pkg::OP_LD  | 8'h0F, 8'h00);   // src = 15
        send_request(nce_pkg::OP_ADD | 8'h0F, 8'h00);   // 15 + 15: carry out
        send_request(8'hBF, 8'h00);                     // jnc with carry set: fall through
        send_request(nce_pkg::OP_SUB, 8'h00);           // 15 - 0: carry clears
        send_request(nce_pkg::OP_XOR | 8'h0F, 8'h00);
        send_request(nce_pkg::OP_OR, 8'h00);
        send_request(nce_pkg::OP_JNC, 8'h00);           // jnc to address 0, taken
        send_request(nce_pkg::OP_LD, 8'h00);            // src = 0
        send_request(nce_pkg::OP_SUB | 8'h0F, 8'h00);   // 0 - 15: borrow
        send_request(nce_pkg::OP_NOT, 8'h00);
        send_request(nce_pkg::OP_LDI | 8'h08, 8'h00);
        send_request(nce_pkg::OP_MOVS, 8'h00);          // src = 8
        send_request(nce_pkg::OP_ROL, 8'h00);           // bit 3 wraps into bit 0
        send_request(nce_pkg::OP_ROR, 8'h00);
        send_request(nce_pkg::OP_LSH, 8'h00);           // bit 3 into carry
        send_request(nce_pkg::OP_RSH, 8'h00);
        send_request(nce_pkg::OP_IN, 8'hFF);            // only the low nibble is kept
        send_request(nce_pkg::OP_OUT, 8'hA0);
        send_request(nce_pkg::OP_BELL, 8'h00);
        send_request(8'hFF, 8'h00);                     // call 63; the ret that follows returns to the link
        send_request(nce_pkg::OP_RET, 8'h00);
        send_request(OP_UNKNOWN_FIRST, 8'h00);
        send_request(OP_UNKNOWN_LAST, 8'h00);
        send_request(nce_pkg::OP_HALT, 8'h00);
        send_request(nce_pkg::OP_ADD | 8'h0F, 8'h00);   // still executes while halted
        send_request(nce_pkg::OP_CALL, 8'h00);          // call 0

        // Random part; once partway through, hold the sender until every
        // outstanding result has drained.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PAUSE_AT) begin
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (pending != 0);
            end
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_phase = 1'b1;
            send_request(random_instruction(), 8'($urandom_range(0, 255)));
        end
        i_in_valid <= 1'b0;

        // Drain: wait for the last results, then keep watching for anything extra
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d instruction requests (directed and random), checked %0d results,",
                 sent_count, checked);
        $display("with random idling on both channels and a drain pause midway.");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
